### hdl/wak_pkg.sv
// Shared types and constants for the three-axis window average Kalman block.
// No dependencies; imported by wak_lane, wak_merge and the top module.
package wak_pkg;

  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned SMP_W    = 20;   // input sample, signed milli-degrees
  localparam int unsigned EST_W    = 32;   // output estimate, integer part
  localparam int unsigned WL_W     = 7;    // window_length register
  localparam int unsigned H_W      = 24;   // measure_gain, Q8.16
  localparam int unsigned P_W      = 32;   // variance and noise, Q16.16
  localparam int unsigned FRAC     = 16;
  localparam int unsigned X_W      = 48;   // estimate, Q32.16
  localparam int unsigned HP_W     = H_W + P_W - FRAC;
  localparam int unsigned DIV_N_W  = HP_W + FRAC;  // divider dividend
  localparam int unsigned DIV_D_W  = HP_W + H_W - FRAC + 1;  // divisor HPH+R
  localparam int unsigned MUL_W    = 33;
  localparam int unsigned PROD_W   = 2 * MUL_W;
  localparam int unsigned ACC_W    = 58;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned IN_W     = 64;
  localparam int unsigned OUT_W    = NUM_AXES * EST_W;

  localparam int unsigned DEF_MAX_WINDOW    = 64;
  localparam logic [P_W-1:0] DEF_INIT_VARIANCE = 32'd65536;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_WINDOW      = 3'd0;
  localparam logic [2:0] REG_GAIN        = 3'd1;
  localparam logic [2:0] REG_ROLL_RN     = 3'd2;
  localparam logic [2:0] REG_PITCH_RN    = 3'd3;
  localparam logic [2:0] REG_YAW_RN      = 3'd4;
  localparam logic [2:0] REG_ROLL_QN     = 3'd5;
  localparam logic [2:0] REG_PITCH_QN    = 3'd6;
  localparam logic [2:0] REG_YAW_QN      = 3'd7;

  typedef enum logic [4:0] {
    S_IDLE, S_ZSTART, S_ZDIV, S_HP, S_HPH_HI, S_HPH_LO, S_DEN, S_KSTART, S_KDIV,
    S_HX_HI, S_HX_LO, S_INNOV, S_CI_HI, S_CI_LO, S_EST, S_FAC, S_NP, S_DONE
  } lane_state_e;

  typedef struct packed {
    logic acc;    // add this word to the window sum
    logic close;  // this word completes the window
  } lane_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_sts_t;

endpackage

### hdl/wak_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module wak_div #(
  parameter int unsigned DVD_W = 56,
  parameter int unsigned DVS_W = 49
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W:0]   trial, diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    diff  = trial - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### hdl/wak_lane.sv
// One axis: window sum, mean, and scalar Kalman update on a shared multiplier.
// Depends on wak_pkg and wak_div.
module wak_lane
  import wak_pkg::*;
#(
  parameter int unsigned     MAX_WINDOW    = 64,
  parameter logic [31:0]     INIT_VARIANCE = 32'd65536,
  parameter int unsigned     N_W           = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wak_pkg::lane_ctl_t             ctl_i,
  input  logic signed [wak_pkg::SMP_W-1:0] sample_i,
  input  logic [N_W-1:0]                 n_i,
  input  logic [wak_pkg::H_W-1:0]        h_i,
  input  logic [wak_pkg::P_W-1:0]        r_i,
  input  logic [wak_pkg::P_W-1:0]        q_i,
  input  logic                           ack_i,
  output wak_pkg::lane_sts_t             sts_o,
  output logic [wak_pkg::EST_W-1:0]      est_o
);

  import wak_pkg::*;

  localparam int unsigned SUM_W = SMP_W + $clog2(MAX_WINDOW);
  localparam logic signed [PROD_W-1:0] CORR_LIM = PROD_W'({1'b1, 49'h0});

  function automatic logic signed [X_W-1:0] sat_x(input logic signed [ACC_W-1:0] v);
    logic hi_same;
    hi_same = (v[ACC_W-1:X_W-1] == '0) || (v[ACC_W-1:X_W-1] == '1);
    if (hi_same) return v[X_W-1:0];
    else if (v[ACC_W-1]) return {1'b1, {(X_W-1){1'b0}}};
    else return {1'b0, {(X_W-1){1'b1}}};
  endfunction

  lane_state_e state_q, state_d;

  logic signed [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]         mag;
  logic                     neg_q;
  logic signed [X_W-1:0]    z_q, x_q, innov_q;
  logic [HP_W-1:0]          hp_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [DIV_D_W-1:0]       den_q;
  logic [P_W-1:0]           k_q, p_q;
  logic signed [PROD_W-1:0] prod_q, prod_w, corr;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic [HP_W-1:0]          kh;
  logic [FRAC:0]            factor;
  logic [P_W:0]             np;
  logic signed [ACC_W-1:0]  hx, tot;

  logic                     div_start, div_done;
  logic [DIV_N_W-1:0]       div_dvd, div_quot;
  logic [DIV_D_W-1:0]       div_dvs;

  wak_div #(.DVD_W(DIV_N_W), .DVS_W(DIV_D_W)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_dvd), .divisor_i(div_dvs),
    .done_o(div_done), .quot_o(div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (ctl_i.acc && ctl_i.close) state_d = S_ZSTART;
      S_ZSTART: state_d = S_ZDIV;
      S_ZDIV:   if (div_done) state_d = S_HP;
      S_HP:     state_d = S_HPH_HI;
      S_HPH_HI: state_d = S_HPH_LO;
      S_HPH_LO: state_d = S_DEN;
      S_DEN:    state_d = S_KSTART;
      S_KSTART: state_d = S_KDIV;
      S_KDIV:   if (div_done) state_d = S_HX_HI;
      S_HX_HI:  state_d = S_HX_LO;
      S_HX_LO:  state_d = S_INNOV;
      S_INNOV:  state_d = S_CI_HI;
      S_CI_HI:  state_d = S_CI_LO;
      S_CI_LO:  state_d = S_EST;
      S_EST:    state_d = S_FAC;
      S_FAC:    state_d = S_NP;
      S_NP:     state_d = S_DONE;
      S_DONE:   if (ack_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // multiplier operands, divider launch and the combinational update sums
  always_comb begin
    mag    = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : sum_q;
    kh     = prod_q[HP_W+FRAC-1:FRAC];
    factor = (kh >= HP_W'(65536)) ? '0 : ((FRAC+1)'(65536) - {1'b0, kh[FRAC-1:0]});
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      S_HP: begin
        mul_a = MUL_W'(h_i);
        mul_b = MUL_W'(p_q);
      end
      S_HPH_HI: begin
        mul_a = MUL_W'(prod_q[HP_W+FRAC-1:2*FRAC]);
        mul_b = MUL_W'(h_i);
      end
      S_HPH_LO: begin
        mul_a = MUL_W'(hp_q[FRAC-1:0]);
        mul_b = MUL_W'(h_i);
      end
      S_HX_HI: begin
        mul_a = {x_q[X_W-1], x_q[X_W-1:FRAC]};
        mul_b = MUL_W'(h_i);
      end
      S_HX_LO: begin
        mul_a = MUL_W'(x_q[FRAC-1:0]);
        mul_b = MUL_W'(h_i);
      end
      S_CI_HI: begin
        mul_a = MUL_W'(k_q);
        mul_b = {innov_q[X_W-1], innov_q[X_W-1:FRAC]};
      end
      S_CI_LO: begin
        mul_a = MUL_W'(k_q);
        mul_b = MUL_W'(innov_q[FRAC-1:0]);
      end
      S_EST: begin
        mul_a = MUL_W'(k_q);
        mul_b = MUL_W'(h_i);
      end
      S_FAC: begin
        mul_a = MUL_W'(factor);
        mul_b = MUL_W'(p_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    div_start = (state_q == S_ZSTART) || (state_q == S_KSTART);
    if (state_q == S_KSTART) begin
      div_dvd = {hp_q, {FRAC{1'b0}}};
      div_dvs = den_q;
    end else begin
      div_dvd = DIV_N_W'({mag, {FRAC{1'b0}}});
      div_dvs = DIV_D_W'(n_i);
    end
    hx   = acc_q + ACC_W'(prod_q >>> FRAC);
    tot  = ACC_W'(x_q) + acc_q + ACC_W'(prod_q >>> FRAC);
    corr = (prod_q > CORR_LIM) ? CORR_LIM : ((prod_q < -CORR_LIM) ? -CORR_LIM : prod_q);
    np   = {1'b0, prod_q[P_W+FRAC-1:FRAC]} + {1'b0, q_i};
  end

  assign prod_w = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sum_q   <= '0;
      x_q     <= '0;
      p_q     <= INIT_VARIANCE;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE:   if (ctl_i.acc) sum_q <= sum_q + SUM_W'(sample_i);
        S_ZSTART: sum_q <= '0;
        S_EST:    x_q <= sat_x(tot);
        S_NP:     p_q <= np[P_W] ? '1 : np[P_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_w;
    case (state_q)
      S_ZSTART: neg_q <= sum_q[SUM_W-1];
      S_ZDIV:   if (div_done) begin
        z_q <= neg_q ? -$signed(X_W'(div_quot)) : $signed(X_W'(div_quot));
      end
      S_HPH_HI: hp_q <= prod_q[HP_W+FRAC-1:FRAC];
      S_HPH_LO: acc_q <= ACC_W'(prod_q);
      S_DEN:    den_q <= DIV_D_W'(acc_q) + DIV_D_W'(prod_q[HP_W+FRAC-1:FRAC])
                         + DIV_D_W'(r_i);
      S_KDIV:   if (div_done) begin
        if (den_q == '0) k_q <= (hp_q != '0) ? '1 : '0;
        else if (div_quot[DIV_N_W-1:P_W] != '0) k_q <= '1;
        else k_q <= div_quot[P_W-1:0];
      end
      S_HX_LO:  acc_q <= ACC_W'(prod_q);
      S_INNOV:  innov_q <= sat_x(ACC_W'(z_q) - hx);
      S_CI_LO:  acc_q <= ACC_W'(corr);
      default:  ;
    endcase
  end

  assign sts_o.busy = (state_q != S_IDLE);
  assign sts_o.done = (state_q == S_DONE);
  assign est_o      = x_q[X_W-1:FRAC];

endmodule

### hdl/wak_merge.sv
// Output stage: joins the three lane estimates into one result word.
// Depends on wak_pkg.
module wak_merge
  import wak_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wak_pkg::lane_sts_t            sts_i [wak_pkg::NUM_AXES],
  input  logic [wak_pkg::EST_W-1:0]     est_i [wak_pkg::NUM_AXES],
  output logic                          ack_o,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [wak_pkg::OUT_W-1:0]     data_o
);

  import wak_pkg::*;

  logic             valid_q, valid_d, all_done, take;
  logic [OUT_W-1:0] data_q;

  always_comb begin
    all_done = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) all_done = all_done & sts_i[a].done;
    take    = all_done && (!valid_q || ready_i);
    valid_d = take || (valid_q && !ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (take) data_q <= {est_i[2], est_i[1], est_i[0]};
  end

  assign ack_o   = take;
  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hdl/window_average_kalman_3axis_top.sv
// Three-axis window average with a scalar Kalman step per axis.
// A word that closes a window starts in each lane a divider pass for the mean, then
// multiplier steps for HPH+R, a second divider pass for the gain (each pass gives a
// 56-bit quotient) and the steps for the estimate and the new variance.
// Throughput: one word per cycle inside a window. After the closing word the
// input holds off while the lanes are busy, and longer if the previous result still
// sits unread in the output register. Reset is asynchronous, active low: sums,
// counter and estimates clear, variances load INIT_VARIANCE, registers reload.
module window_average_kalman_3axis_top
  import wak_pkg::*;
#(
  parameter int unsigned MAX_WINDOW    = wak_pkg::DEF_MAX_WINDOW,
  parameter logic [31:0] INIT_VARIANCE = wak_pkg::DEF_INIT_VARIANCE
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [19:0] roll_mdeg, [39:20] pitch_mdeg, [59:40] yaw_mdeg, [63:60] zero
  input  logic [wak_pkg::IN_W-1:0]    s_axis_tdata,
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [31:0] roll_estimate, [63:32] pitch_estimate, [95:64] yaw_estimate
  output logic [wak_pkg::OUT_W-1:0]   m_axis_tdata,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wak_pkg::ADDR_W-1:0]  paddr,
  input  logic [wak_pkg::DATA_W-1:0]  pwdata,
  output logic [wak_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  import wak_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned N_W = (CW > WL_W) ? CW : WL_W;

  // configuration registers
  logic [WL_W-1:0] wl_q;
  logic [H_W-1:0]  gain_q;
  logic [P_W-1:0]  rn_q [NUM_AXES];
  logic [P_W-1:0]  qn_q [NUM_AXES];
  logic            wr_en;
  logic [2:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= WL_W'(8);
      gain_q <= H_W'(65536);
      for (int a = 0; a < NUM_AXES; a++) begin
        rn_q[a] <= P_W'(65536);
        qn_q[a] <= P_W'(655);
      end
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW:   wl_q    <= pwdata[WL_W-1:0];
        REG_GAIN:     gain_q  <= pwdata[H_W-1:0];
        REG_ROLL_RN:  rn_q[0] <= pwdata;
        REG_PITCH_RN: rn_q[1] <= pwdata;
        REG_YAW_RN:   rn_q[2] <= pwdata;
        REG_ROLL_QN:  qn_q[0] <= pwdata;
        REG_PITCH_QN: qn_q[1] <= pwdata;
        REG_YAW_QN:   qn_q[2] <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW:   prdata = DATA_W'(wl_q);
      REG_GAIN:     prdata = DATA_W'(gain_q);
      REG_ROLL_RN:  prdata = rn_q[0];
      REG_PITCH_RN: prdata = rn_q[1];
      REG_YAW_RN:   prdata = rn_q[2];
      REG_ROLL_QN:  prdata = qn_q[0];
      REG_PITCH_QN: prdata = qn_q[1];
      REG_YAW_QN:   prdata = qn_q[2];
      default:      prdata = '0;
    endcase
  end

  // Effective window: zero acts as one, clip to MAX_WINDOW.
  logic [N_W-1:0] n_eff, cnt_q, cnt_d, cnt_inc;
  logic           s_fire, close;
  lane_ctl_t      ctl;
  lane_sts_t      sts [NUM_AXES];
  logic [EST_W-1:0] est [NUM_AXES];
  logic           any_busy, ack;

  always_comb begin
    if (wl_q == '0) n_eff = N_W'(1);
    else if (N_W'(wl_q) > N_W'(MAX_WINDOW)) n_eff = N_W'(MAX_WINDOW);
    else n_eff = N_W'(wl_q);
    any_busy = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) any_busy = any_busy | sts[a].busy;
  end

  // Take words only while every lane sits idle; a finished result waiting
  // in the output register holds off the next window until it is read.
  assign s_axis_tready = !any_busy;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cnt_inc       = cnt_q + 1'b1;
  // A lowered window length closes on the next word once the count reaches it.
  assign close         = (cnt_inc >= n_eff);
  assign cnt_d         = close ? '0 : cnt_inc;
  assign ctl.acc       = s_fire;
  assign ctl.close     = close;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (s_fire) cnt_q <= cnt_d;
  end

  // one lane per axis, all stepping in lockstep
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    wak_lane #(
      .MAX_WINDOW(MAX_WINDOW), .INIT_VARIANCE(INIT_VARIANCE), .N_W(N_W)
    ) u_lane (
      .clk_i, .rst_ni,
      .ctl_i   (ctl),
      .sample_i(s_axis_tdata[a*SMP_W +: SMP_W]),
      .n_i     (n_eff),
      .h_i     (gain_q),
      .r_i     (rn_q[a]),
      .q_i     (qn_q[a]),
      .ack_i   (ack),
      .sts_o   (sts[a]),
      .est_o   (est[a])
    );
  end

  // merge the lane estimates into the result register
  wak_merge u_merge (
    .clk_i, .rst_ni,
    .sts_i  (sts),
    .est_i  (est),
    .ack_o  (ack),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (m_axis_tdata)
  );

endmodule
